// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CHT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/cht_pkg.sv =====
// ============================================================================
// cht_pkg
// Shared constants and types for the chained hash table.
// ============================================================================
`default_nettype none

package cht_pkg;

    localparam int BUCKETS    = 1021;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // node index incl. the null code, and plain pool index
    localparam int NODE_W = $clog2(BUCKETS + 1);
    localparam int IDX_W  = $clog2(BUCKETS);

    localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(BUCKETS);

    // key mod BUCKETS by reciprocal multiply, one correction step
    localparam int RECIP_SHIFT = KEY_BITS + NODE_W;
    localparam int RECIP_W     = RECIP_SHIFT - IDX_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((128'd1 << RECIP_SHIFT) / BUCKETS);
    localparam int PROD_W = KEY_BITS + RECIP_W;

    localparam int IN_RAW_W  = 2 + KEY_BITS + VALUE_BITS;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_W     = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_HEAD,
        S_HEAD_DATA,
        S_WALK,
        S_CHECK,
        S_UNLINK,
        S_RELEASE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/chained_hash_table_core.sv =====
// Flow: a request passes the hash states (HASH1 to HASH3) and the head read (HEAD,
//   HEAD_DATA), then a WALK and CHECK pair per chain node walked, plus UNLINK and
//   RELEASE on a delete hit; unknown ops and inserts into a full table go straight to DONE.
// Requests: one at a time; the next word is taken only once the status word of the
//   last has been loaded into a free output slot.
// Reset: asynchronous, active low. After reset a clearing pass writes null to
//   every bucket head before the first request is taken.
// ============================================================================
// chained_hash_table_core
// Separate-chaining hash table over a fixed node pool held in block RAMs.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module chained_hash_table_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // [1:0] operation, [33:2] lookup_key, [65:34] entry_value, rest zero
    input  wire logic [cht_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [1:0] status, rest zero
    output logic      [cht_pkg::OUT_W-1:0] m_tdata
);

    import cht_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [KEY_BITS-1:0]   qb_reg, qb_next;
    logic [IDX_W-1:0]      bucket_reg, bucket_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic [NODE_W-1:0]     prev_reg, prev_next;
    logic [NODE_W-1:0]     nxt_reg, nxt_next;
    logic [NODE_W-1:0]     steps_reg, steps_next;
    status_t               res_reg, res_next;

    logic [NODE_W-1:0] free_top_reg, free_top_next;
    logic [NODE_W-1:0] count_reg, count_next;
    logic [NODE_W-1:0] low_reg, low_next;
    logic [IDX_W-1:0]  clr_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;

    // memory ports
    logic                  head_we;
    logic [IDX_W-1:0]      head_waddr;
    logic [NODE_W-1:0]     head_wdata, head_rdata;
    logic                  kv_we;
    logic [KEY_BITS-1:0]   key_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [NODE_W-1:0]     link_wdata, link_rdata;
    logic                  free_we;
    logic [IDX_W-1:0]      free_rdata;
    logic [NODE_W-1:0]     pop_idx;

    logic in_fire, out_free, table_full, head_live, nxt_live, key_match;
    logic walk_more, ins_more;
    logic [NODE_W:0]   steps_inc;
    logic [NODE_W:0]   rem_raw, rem_fix;
    logic [NODE_W-1:0] pop_pick;
    logic [KEY_BITS-1:0] quot;

    cht_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(bucket_reg), .rdata(head_rdata)
    );

    cht_ram #(.WIDTH(KEY_BITS), .DEPTH(BUCKETS)) u_key (
        .clk(clk), .we(kv_we), .waddr(node_reg[IDX_W-1:0]), .wdata(key_reg),
        .raddr(cur_reg[IDX_W-1:0]), .rdata(key_rdata)
    );

    // values are kept with each node but never read back
    cht_ram #(.WIDTH(VALUE_BITS), .DEPTH(BUCKETS)) u_value (
        .clk(clk), .we(kv_we), .waddr(node_reg[IDX_W-1:0]), .wdata(value_reg),
        .raddr(cur_reg[IDX_W-1:0]), .rdata()
    );

    cht_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(cur_reg[IDX_W-1:0]), .rdata(link_rdata)
    );

    cht_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_free (
        .clk(clk), .we(free_we), .waddr(free_top_reg[IDX_W-1:0]),
        .wdata(cur_reg[IDX_W-1:0]), .raddr(pop_idx[IDX_W-1:0]), .rdata(free_rdata)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(OUT_W-2){1'b0}}, status_reg};
    assign out_free   = !out_valid_reg || m_tready;
    assign table_full = (count_reg >= NODE_W'(BUCKETS)) || (free_top_reg == '0);

    assign head_live  = head_rdata < NIL_NODE;
    assign nxt_live   = link_rdata < NIL_NODE;
    assign key_match  = key_rdata == key_reg;
    assign steps_inc  = {1'b0, steps_reg} + 1'b1;
    assign ins_more   = nxt_live && (steps_reg < NODE_W'(BUCKETS));
    assign walk_more  = nxt_live && (steps_inc < (NODE_W+1)'(BUCKETS));

    // remainder from the registered quotient estimate
    assign quot    = KEY_BITS'(prod_reg >> RECIP_SHIFT);
    assign rem_raw = (NODE_W+1)'(key_reg - qb_reg);
    assign rem_fix = (rem_raw >= (NODE_W+1)'(BUCKETS)) ?
                     rem_raw - (NODE_W+1)'(BUCKETS) : rem_raw;

    // free stack entries below the low mark were never written; their node index is computed instead
    assign pop_idx  = free_top_reg - 1'b1;
    assign pop_pick = (pop_idx < low_reg) ? NODE_W'(BUCKETS - 1) - pop_idx
                                          : NODE_W'(free_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tdata[1:0])
                        OP_INSERT: state_next = table_full ? S_DONE : S_HASH1;
                        OP_SEARCH: state_next = S_HASH1;
                        OP_DELETE: state_next = S_HASH1;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_HASH1:     state_next = S_HASH2;
            S_HASH2:     state_next = S_HASH3;
            S_HASH3:     state_next = S_HEAD;
            S_HEAD:      state_next = S_HEAD_DATA;
            S_HEAD_DATA: state_next = head_live ? S_WALK : S_DONE;
            S_WALK:      state_next = S_CHECK;
            S_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    state_next = ins_more ? S_WALK : S_DONE;
                end
                else if (key_match)
                begin
                    state_next = (op_reg == OP_DELETE) ? S_UNLINK : S_DONE;
                end
                else
                begin
                    state_next = walk_more ? S_WALK : S_DONE;
                end
            end
            S_UNLINK:    state_next = S_RELEASE;
            S_RELEASE:   state_next = S_DONE;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        qb_next        = KEY_BITS'(quot * KEY_BITS'(BUCKETS));
        bucket_next    = bucket_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        free_top_next  = free_top_reg;
        count_next     = count_reg;
        low_next       = low_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;

        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = node_reg;
        kv_we      = 1'b0;
        link_we    = 1'b0;
        link_waddr = node_reg[IDX_W-1:0];
        link_wdata = NIL_NODE;
        free_we    = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NIL_NODE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tdata[1:0] == OP_INSERT && table_full)
                    begin
                        res_next = ST_FULL;
                    end
                    else
                    begin
                        res_next = ST_MISSING;
                    end
                end
            end
            S_HASH3:
            begin
                bucket_next = IDX_W'(rem_fix);
                if (op_reg == OP_INSERT)
                begin
                    free_top_next = pop_idx;
                    node_next     = (pop_pick >= NIL_NODE) ? '0 : pop_pick;
                end
            end
            S_HEAD_DATA:
            begin
                cur_next   = head_rdata;
                prev_next  = NIL_NODE;
                steps_next = '0;
                if (op_reg == OP_INSERT)
                begin
                    kv_we   = 1'b1;
                    link_we = 1'b1;
                    if (!head_live)
                    begin
                        head_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                        res_next   = ST_OK;
                    end
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (ins_more)
                    begin
                        cur_next   = link_rdata;
                        steps_next = NODE_W'(steps_inc);
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = cur_reg[IDX_W-1:0];
                        link_wdata = node_reg;
                        count_next = count_reg + 1'b1;
                        res_next   = ST_OK;
                    end
                end
                else if (key_match)
                begin
                    nxt_next = link_rdata;
                    if (op_reg == OP_SEARCH)
                    begin
                        res_next = ST_OK;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = NODE_W'(steps_inc);
                end
            end
            S_UNLINK:
            begin
                if (prev_reg < NIL_NODE)
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[IDX_W-1:0];
                    link_wdata = nxt_reg;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = nxt_reg;
                end
            end
            S_RELEASE:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg[IDX_W-1:0];
                link_wdata = NIL_NODE;
                if (free_top_reg < NODE_W'(BUCKETS))
                begin
                    free_we       = 1'b1;
                    free_top_next = free_top_reg + 1'b1;
                    if (free_top_reg < low_reg)
                    begin
                        low_next = free_top_reg;
                    end
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                res_next = ST_OK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_top_reg  <= NODE_W'(BUCKETS);
            count_reg     <= '0;
            low_reg       <= NODE_W'(BUCKETS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            free_top_reg  <= free_top_next;
            count_reg     <= count_next;
            low_reg       <= low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= s_tdata[1:0];
            key_reg   <= s_tdata[2 +: KEY_BITS];
            value_reg <= s_tdata[2 + KEY_BITS +: VALUE_BITS];
        end
        prod_reg   <= PROD_W'(key_reg) * PROD_W'(RECIP);
        qb_reg     <= qb_next;
        bucket_reg <= bucket_next;
        node_reg   <= node_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        steps_reg  <= steps_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // pool bookkeeping balances between requests
    `CHT_ASSERT_IMP(a_pool_balance, state_reg == S_IDLE,
        (free_top_reg + count_reg) == NODE_W'(BUCKETS), "free and stored counts disagree")
    // no request taken during the head clearing pass
    `CHT_ASSERT_IMP(a_no_accept_clear, state_reg == S_CLEAR, !s_tready,
        "request accepted while clearing")
    // a result is only loaded into a free output slot
    `CHT_ASSERT_IMP(a_out_slot, state_reg == S_DONE && state_next == S_IDLE, out_free,
        "result loaded over a pending word")
    // walk never runs past the pool size
    `CHT_ASSERT_IMP(a_steps_bound, state_reg == S_CHECK, steps_reg <= NODE_W'(BUCKETS),
        "chain walk overran the pool")

endmodule

`default_nettype wire

// ===== design/cht_ram.sv =====
// ============================================================================
// cht_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== dv/chained_hash_table_core_tb.sv =====
// ============================================================================
// chained_hash_table_core_tb
// Random and directed insert/search/delete traffic against a scoreboard that
// keeps its own chained table; every status word is checked in order.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

class status_scoreboard;
    localparam int NB = cht_pkg::BUCKETS;
    localparam int NIL = cht_pkg::BUCKETS;

    int unsigned head[NB];
    bit [31:0]   nkey[NB];
    int unsigned nlink[NB];
    int unsigned free_list[NB];
    int unsigned free_cnt;
    int unsigned used;
    cht_pkg::status_t pending[$];
    int errors;

    function void clear();
        for (int i = 0; i < NB; i++)
        begin
            head[i] = NIL;
            nlink[i] = NIL;
            free_list[i] = NB - 1 - i;
        end
        free_cnt = NB;
        used = 0;
        errors = 0;
        pending.delete();
    endfunction

    function cht_pkg::status_t table_op(bit [1:0] op, bit [31:0] key);
        int unsigned b, cur, prev, node, steps;
        b = key % NB;
        if (op == cht_pkg::OP_INSERT)
        begin
            if (used >= NB || free_cnt == 0)
                return cht_pkg::ST_FULL;
            free_cnt--;
            node = free_list[free_cnt];
            nkey[node] = key;
            nlink[node] = NIL;
            if (head[b] == NIL)
                head[b] = node;
            else
            begin
                cur = head[b];
                while (nlink[cur] != NIL)
                    cur = nlink[cur];
                nlink[cur] = node;
            end
            used++;
            return cht_pkg::ST_OK;
        end
        if (op != cht_pkg::OP_SEARCH && op != cht_pkg::OP_DELETE)
            return cht_pkg::ST_MISSING;
        cur = head[b];
        prev = NIL;
        steps = 0;
        while (cur != NIL && steps < NB)
        begin
            if (nkey[cur] == key)
            begin
                if (op == cht_pkg::OP_DELETE)
                begin
                    if (prev != NIL)
                        nlink[prev] = nlink[cur];
                    else
                        head[b] = nlink[cur];
                    nlink[cur] = NIL;
                    free_list[free_cnt] = cur;
                    free_cnt++;
                    used--;
                end
                return cht_pkg::ST_OK;
            end
            prev = cur;
            cur = nlink[cur];
            steps++;
        end
        return cht_pkg::ST_MISSING;
    endfunction

    function void note_request(bit [1:0] op, bit [31:0] key);
        pending.push_back(table_op(op, key));
    endfunction

    function void check_status(bit [7:0] word);
        cht_pkg::status_t exp_st;
        if (pending.size() == 0)
        begin
            $error("status word with nothing expected: %0d", word[1:0]);
            errors++;
            return;
        end
        exp_st = pending.pop_front();
        if (word[1:0] != exp_st)
        begin
            $error("status: expected %0d actual %0d", exp_st, word[1:0]);
            errors++;
        end
        if (word[7:2] != 0)
        begin
            $error("pad: expected 0 actual %0h", word[7:2]);
            errors++;
        end
    endfunction
endclass

module chained_hash_table_core_tb;
    import cht_pkg::*;

    localparam int MAX_CYCLES = 2_000_000;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [OUT_W-1:0] m_tdata;

    status_scoreboard sb;
    bit   [31:0] keys_seen[$];
    bit          quiet_src;
    bit          quiet_snk;
    int          cycles;

    chained_hash_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one request word; random idle before it unless in the quiet stretch
    task automatic send_request(bit [1:0] op, bit [31:0] key, bit [31:0] val);
        while (!quiet_src && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 66){1'b0}}, val, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, key);
        if (key != 0 || $urandom_range(7) == 0)
            keys_seen.push_back(key);
        if (keys_seen.size() > 64)
            void'(keys_seen.pop_front());
        @(negedge clk);
    endtask

    function automatic bit [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45 && keys_seen.size() > 0)
            return keys_seen[$urandom_range(keys_seen.size() - 1)];
        if (r < 60)
            return $urandom_range(9) * BUCKETS + $urandom_range(2);
        return $urandom;
    endfunction

    always @(negedge clk)
        m_tready <= quiet_snk ? 1'b1 : ($urandom_range(99) >= 10);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_status(m_tdata);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int r;
        int drain;
        bit [1:0] op;
        sb = new();
        sb.clear();
        cycles    = 0;
        quiet_src = 1'b0;
        quiet_snk = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every op, duplicates, unknown op, bucket collisions
        send_request(OP_SEARCH, 32'h0, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'h1234_5678);
        send_request(OP_INSERT, BUCKETS, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 2 * BUCKETS, 32'h5A5A_5A5A);
        send_request(OP_SEARCH, 2 * BUCKETS, 32'h0);
        send_request(OP_SEARCH, 3 * BUCKETS, 32'h0);
        send_request(OP_DELETE, 32'h0, 32'h0);
        send_request(OP_SEARCH, 32'h0, 32'h0);
        send_request(OP_DELETE, BUCKETS, 32'h0);
        send_request(OP_DELETE, 32'h0, 32'h0);
        send_request(OP_SEARCH, 32'h0, 32'h0);
        send_request(OP_SEARCH, 2 * BUCKETS, 32'hFFFF_FFFF);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0);

        // random: many picks from recent keys, a quiet stretch in the middle
        for (int i = 0; i < 400; i++)
        begin
            quiet_src = (i >= 150 && i < 250);
            quiet_snk = quiet_src;
            r = $urandom_range(99);
            op = (r < 45) ? OP_INSERT : (r < 70) ? OP_SEARCH : (r < 97) ? OP_DELETE : 2'd3;
            send_request(op, pick_key(), $urandom);
        end
        // fill past capacity to reach the full status, then drain some
        for (int i = 0; i < 1050; i++)
            send_request(OP_INSERT, $urandom_range(40000), $urandom);
        for (int i = 0; i < 80; i++)
            send_request(($urandom_range(1) ? OP_DELETE : OP_SEARCH),
                         $urandom_range(40000), $urandom);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 3000)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

// ===== chained_hash_table_core.f =====
+incdir+design
design/cht_pkg.sv
design/cht_ram.sv
design/chained_hash_table_core.sv
dv/chained_hash_table_core_tb.sv
